// ----- design/keds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package keds_pkg;

	// Configuration register map.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SELECT_MODE = 1'b1;

	// Field widths of the stream payloads.
	localparam int LABEL_W  = 64;
	localparam int COUNT_W  = 5;
	localparam int OUT_W    = 72;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_CALC,
		ST_COMMIT,
		ST_EMIT
	} keds_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan;
		logic calc;
		logic commit;
		logic emit;
	} keds_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic total_zero;
		logic scan_done;
		logic last;
		logic out_free;
	} keds_status_t;

endpackage

`default_nettype wire

// ----- design/keds_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module keds_ctrl
	import keds_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire keds_status_t status,
	output keds_cmd_t         cmd
);

	keds_state_t state_q;
	keds_state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_next = status.total_zero ? ST_CALC : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.scan_done) begin
					state_next = ST_CALC;
				end
			end
			ST_CALC: begin
				state_next = ST_COMMIT;
			end
			ST_COMMIT: begin
				state_next = status.last ? ST_EMIT : ST_IDLE;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd        = '0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = status.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/keds_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module keds_dp
	import keds_pkg::*;
#(
	parameter int MAX_KEEP = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire keds_cmd_t             cmd,
	output keds_status_t               status,
	input  wire logic [LABEL_W-1:0]    label,
	input  wire logic                  is_last,
	input  wire logic [CFG_DATA_W-1:0] keep_count,
	input  wire logic                  select_mode,
	input  wire logic                  m_tready,
	output logic                       m_tvalid,
	output logic [LABEL_W-1:0]         signature,
	output logic [COUNT_W-1:0]         kept_entries
);

	localparam int IW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;
	localparam int CW = $clog2(MAX_KEEP + 1);
	localparam int KW = (CW > CFG_DATA_W) ? CW : CFG_DATA_W;

	logic [LABEL_W-1:0] mem [MAX_KEEP];

	logic [LABEL_W-1:0] label_q;
	logic               last_q;
	logic               seed_q;
	logic               hit_q;
	logic [LABEL_W-1:0] worst_q;
	logic [IW-1:0]      widx_q;
	logic [IW-1:0]      ridx_q;
	logic               rv_q;
	logic [LABEL_W-1:0] rd_data_q;
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      total_q;
	logic [CW-1:0]      seen_q;
	logic [LABEL_W-1:0] sum_q;
	logic [LABEL_W-1:0] delta_q;
	logic               better_q;
	logic [LABEL_W-1:0] out_sig_q;
	logic [COUNT_W-1:0] out_cnt_q;
	logic               out_valid_q;

	logic [KW-1:0] keep_ext;
	logic [KW-1:0] max_ext;
	logic [KW-1:0] keff;
	logic [KW-1:0] seen_ext;
	logic [KW-1:0] total_ext;
	logic          rd_en;
	logic          ins_en;
	logic          rep_en;
	logic          wr_en;
	logic [IW-1:0] wr_addr;
	logic          is_worse;

	// Effective keep count: zero acts as one, anything above the depth as the depth.
	always_comb begin
		keep_ext  = KW'(keep_count);
		max_ext   = KW'(MAX_KEEP);
		seen_ext  = KW'(seen_q);
		total_ext = KW'(total_q);
		if (keep_count == '0) begin
			keff = KW'(1);
		end else if (keep_ext > max_ext) begin
			keff = max_ext;
		end else begin
			keff = keep_ext;
		end
	end

	assign rd_en    = cmd.scan && (cnt_q < total_q);
	assign ins_en   = cmd.commit && seed_q && !hit_q && (total_q < CW'(MAX_KEEP));
	assign rep_en   = cmd.commit && !seed_q && (total_q != '0) && better_q && !hit_q;
	assign wr_en    = ins_en || rep_en;
	assign wr_addr  = ins_en ? total_q[IW-1:0] : widx_q;
	assign is_worse = select_mode ? (rd_data_q < worst_q) : (rd_data_q > worst_q);

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= label_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[cnt_q[IW-1:0]];
		end
	end

	// Item payload and scan results.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			label_q <= label;
			last_q  <= is_last;
			seed_q  <= (seen_ext < keff);
		end
		if (rd_en) begin
			ridx_q <= cnt_q[IW-1:0];
		end
		if (rv_q && ((ridx_q == '0) || is_worse)) begin
			worst_q <= rd_data_q;
			widx_q  <= ridx_q;
		end
		if (cmd.calc) begin
			delta_q  <= label_q - worst_q;
			better_q <= select_mode ? (label_q > worst_q) : (label_q < worst_q);
		end
		if (cmd.emit) begin
			out_sig_q <= sum_q;
			out_cnt_q <= total_ext[COUNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= 1'b0;
			rv_q        <= 1'b0;
			cnt_q       <= '0;
			total_q     <= '0;
			seen_q      <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rv_q <= rd_en;
			if (cmd.load) begin
				cnt_q <= '0;
				hit_q <= 1'b0;
			end else begin
				if (rd_en) begin
					cnt_q <= cnt_q + CW'(1);
				end
				if (rv_q && (rd_data_q == label_q)) begin
					hit_q <= 1'b1;
				end
			end
			if (cmd.commit && seed_q) begin
				seen_q <= seen_q + CW'(1);
			end
			if (ins_en) begin
				total_q <= total_q + CW'(1);
				sum_q   <= sum_q + label_q;
			end else if (rep_en) begin
				sum_q <= sum_q + delta_q;
			end
			if (cmd.emit) begin
				total_q     <= '0;
				seen_q      <= '0;
				sum_q       <= '0;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign status.total_zero = (total_q == '0);
	assign status.scan_done  = (cnt_q == total_q);
	assign status.last       = last_q;
	assign status.out_free   = !out_valid_q || m_tready;

	assign m_tvalid     = out_valid_q;
	assign signature    = out_sig_q;
	assign kept_entries = out_cnt_q;

endmodule

`default_nettype wire

// ----- design/k_extreme_distinct_sum.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Keeps a set of up to keep_count distinct 64-bit labels from a stream that is cut into
// sets by tlast. The first keep_count labels of a set seed it, duplicates collapsing;
// each later label replaces the largest kept entry (select_mode 0) or the smallest
// (select_mode 1) when it is strictly better and not already kept. On the item with
// tlast set, one result item carries the wrapping 64-bit sum of the kept labels and
// their count, and the set is cleared. Items are handled one at a time: an item's scan
// covers every label kept before it, since the label store has a single registered read
// port and is scanned one entry a cycle for membership and for the worst entry; an empty
// set skips the scan. A last item then passes an emit state that loads the output
// register, and waits there while an earlier result has not yet been taken. The sum is
// kept running as entries change, so no summing pass is needed. The store needs no
// clearing after reset. Configuration must be written through cfg_we, cfg_index and
// cfg_data only while the block is idle; the block itself does not enforce this.

module k_extreme_distinct_sum
	import keds_pkg::*;
#(
	parameter int MAX_KEEP = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [63:0]           s_tdata,   // [63:0] label
	input  wire logic                  s_tlast,   // is_last
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_W-1:0]           m_tdata    // [63:0] signature, [68:64] kept_entries
);

	logic [CFG_DATA_W-1:0] keep_count_q;
	logic                  select_mode_q;
	keds_cmd_t             cmd;
	keds_status_t          status;
	logic [LABEL_W-1:0]    signature;
	logic [COUNT_W-1:0]    kept_entries;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q  <= CFG_DATA_W'(4);
			select_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEEP_COUNT: begin
					keep_count_q <= cfg_data;
				end
				REG_SELECT_MODE: begin
					select_mode_q <= cfg_data[0];
				end
				default: begin
					keep_count_q <= keep_count_q;
				end
			endcase
		end
	end

	// The controller sequences load, scan, decision, commit and emit for each item.
	keds_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// The datapath holds the label store, counters, running sum and output register.
	keds_dp #(
		.MAX_KEEP (MAX_KEEP)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.label        (s_tdata),
		.is_last      (s_tlast),
		.keep_count   (keep_count_q),
		.select_mode  (select_mode_q),
		.m_tready     (m_tready),
		.m_tvalid     (m_tvalid),
		.signature    (signature),
		.kept_entries (kept_entries)
	);

	assign m_tdata = {{(OUT_W - LABEL_W - COUNT_W){1'b0}}, kept_entries, signature};

`ifndef SYNTH
	// Items are handled one at a time, so an accepted item closes the input.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while an item was still in work");

	// A result never reports more entries than the store holds.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (32'(m_tdata[68:64]) <= 32'(MAX_KEEP)))
		else $error("result count exceeds the store depth");

	// A fresh result only follows an item that closed its set.
	a_result_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> status.last)
		else $error("result produced without a last item");
`endif

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

// Checks k_extreme_distinct_sum end to end. A short scripted sequence of rows (items and
// register writes) comes first, then phases of random sets, each phase under a fresh
// register setting. A local model of the kept set predicts every result item, and each
// result taken from the block is compared field by field against the oldest prediction.

module testbench;
	import keds_pkg::*;

	localparam int KEEP_LIMIT = 16;

	// Values of the select_mode register.
	localparam logic MODE_KEEP_SMALL = 1'b0;
	localparam logic MODE_KEEP_LARGE = 1'b1;

	// Worst case for the block to go quiet once its last result has been taken:
	// a full set scan plus the handshake overhead, with margin.
	localparam int SETTLE_CYCLES = 30;
	localparam int DRAIN_LIMIT   = 5000;
	localparam int PHASE_ITEMS   = 120;
	localparam int PHASE_COUNT   = 10;

	// One result item: the wrapping sum of the kept labels and their count.
	typedef struct packed {
		logic [63:0]        signature;
		logic [COUNT_W-1:0] kept_entries;
	} set_sum_t;

	// One row of the scripted sequence: either a register write or an item. An item row
	// with a typed result carries the sum that can be read straight off the labels;
	// every other item row is checked against the local model.
	typedef struct {
		bit                  is_write;
		logic [CFG_IDX_W-1:0] reg_index;
		logic [CFG_DATA_W-1:0] reg_value;
		logic [63:0]         label;
		logic                last;
		bit                  typed;
		set_sum_t            typed_sum;
	} script_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [63:0]           s_tdata;   // [63:0] label
	logic                  s_tlast;   // is_last
	logic                  m_tvalid;
	logic                  m_tready;
	logic [OUT_W-1:0]      m_tdata;   // [63:0] signature, [68:64] kept_entries

	// Local copy of the block's state and registers.
	logic [63:0]        kept_store [KEEP_LIMIT];
	int unsigned        kept_now;
	int unsigned        seen_in_set;
	logic [CFG_DATA_W-1:0] keep_reg;
	logic               mode_reg;

	set_sum_t     pending_sums [$];
	script_row_t  script_rows [$];
	int           fail_count;
	int           burst_left;
	int           set_left;

	k_extreme_distinct_sum #(
		.MAX_KEEP(KEEP_LIMIT)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Safety net: a correct run finishes in a small fraction of this time.
	initial begin
		#12_000_000;
		$display("testbench: errors");
		$finish;
	end

	// Effective keep count: zero behaves as one, anything above the store size as the
	// store size.
	function automatic int unsigned effective_keep();
		int unsigned k;
		k = keep_reg;
		if (k < 1) begin
			k = 1;
		end
		if (k > KEEP_LIMIT) begin
			k = KEEP_LIMIT;
		end
		return k;
	endfunction

	// Advances the local kept set by one accepted item. On a last item it returns the
	// sum and count of the set and clears it, exactly as the block should.
	task automatic advance_kept_set(input logic [63:0] label, input logic last,
			output bit has_sum, output set_sum_t sum_out);
		int unsigned k;
		int unsigned worst;
		bit          already;
		bit          better;
		logic [63:0] running;
		k = effective_keep();
		already = 1'b0;
		for (int i = 0; i < kept_now; i++) begin
			if (kept_store[i] == label) begin
				already = 1'b1;
			end
		end
		if (seen_in_set < k) begin
			// Seeding: the label joins the set unless it is already kept.
			if (!already && kept_now < KEEP_LIMIT) begin
				kept_store[kept_now] = label;
				kept_now++;
			end
			seen_in_set++;
		end else if (kept_now > 0) begin
			// Past seeding: find the entry that is worst for the current mode.
			worst = 0;
			for (int i = 1; i < kept_now; i++) begin
				if (mode_reg == MODE_KEEP_SMALL) begin
					if (kept_store[i] > kept_store[worst]) begin
						worst = i;
					end
				end else begin
					if (kept_store[i] < kept_store[worst]) begin
						worst = i;
					end
				end
			end
			better = (mode_reg == MODE_KEEP_SMALL) ? (label < kept_store[worst])
				: (label > kept_store[worst]);
			if (better && !already) begin
				kept_store[worst] = label;
			end
		end
		has_sum = last;
		sum_out = '0;
		if (last) begin
			running = '0;
			for (int i = 0; i < kept_now; i++) begin
				running += kept_store[i];
			end
			sum_out.signature    = running;
			sum_out.kept_entries = kept_now[COUNT_W-1:0];
			kept_now    = 0;
			seen_in_set = 0;
		end
	endtask

	// Presents one item and waits for it to be taken. Called just after a falling edge.
	// The sender runs in bursts; between bursts valid drops for a random gap.
	task automatic offer_item(input logic [63:0] label, input logic last, input bit typed,
			input set_sum_t typed_sum);
		int       gap;
		bit       has_sum;
		set_sum_t predicted;
		if (burst_left <= 0) begin
			// About half the bursts run straight on with no gap at all.
			gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_tvalid = 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 12);
		end
		s_tdata  = label;
		s_tlast  = last;
		s_tvalid = 1'b1;
		@(posedge clk);
		while (!s_tready) begin
			@(posedge clk);
		end
		advance_kept_set(label, last, has_sum, predicted);
		if (has_sum) begin
			pending_sums.push_back(typed ? typed_sum : predicted);
		end
		burst_left--;
		@(negedge clk);
	endtask

	// Brings the block to rest: no item offered, every result taken, and enough cycles
	// for an item that makes no result to work its way through.
	task automatic settle();
		s_tvalid   = 1'b0;
		burst_left = 0;
		while (pending_sums.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes one register and mirrors it in the local copy. The block must be at rest.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		cfg_index = index;
		cfg_data  = value;
		cfg_we    = 1'b1;
		@(negedge clk);
		cfg_we = 1'b0;
		if (index == REG_KEEP_COUNT) begin
			keep_reg = value;
		end else begin
			mode_reg = value[0];
		end
	endtask

	function automatic script_row_t item_row(input logic [63:0] label, input logic last);
		script_row_t r;
		r = '{default: '0};
		r.label = label;
		r.last  = last;
		return r;
	endfunction

	function automatic script_row_t summed_row(input logic [63:0] label,
			input logic [63:0] signature, input int unsigned entries);
		script_row_t r;
		r = item_row(label, 1'b1);
		r.typed = 1'b1;
		r.typed_sum.signature    = signature;
		r.typed_sum.kept_entries = entries[COUNT_W-1:0];
		return r;
	endfunction

	function automatic script_row_t write_row(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_DATA_W-1:0] value);
		script_row_t r;
		r = '{default: '0};
		r.is_write  = 1'b1;
		r.reg_index = index;
		r.reg_value = value;
		return r;
	endfunction

	// Random labels: a small pool so that duplicates and ties are common, values near
	// the top of the range, the two extremes, and fully random values.
	function automatic logic [63:0] pick_label();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return 64'($urandom_range(0, 15));
			4:          return {60'hFFFF_FFFF_FFFF_FFF, 4'($urandom_range(0, 15))};
			5:          return ($urandom_range(0, 1) == 0) ? 64'd0 : {64{1'b1}};
			default:    return {$urandom, $urandom};
		endcase
	endfunction

	// Result side: the receiver stalls in a pattern of its own. It picks at random between
	// always ready, a coin toss per cycle, and long stalls, and holds each for a random run.
	int stall_style;
	int style_left;

	always @(negedge clk) begin
		if (style_left <= 0) begin
			stall_style = $urandom_range(0, 2);
			style_left  = $urandom_range(20, 80);
		end
		style_left--;
		case (stall_style)
			0:       m_tready <= 1'b1;
			1:       m_tready <= ($urandom_range(0, 1) == 0);
			default: m_tready <= ($urandom_range(0, 9) == 0);
		endcase
	end

	// Each result taken is compared with the oldest prediction still waiting.
	always @(posedge clk) begin
		set_sum_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_sums.size() == 0) begin
				$error("result item with no prediction waiting: signature %h kept_entries %0d",
					m_tdata[63:0], m_tdata[68:64]);
				fail_count++;
			end else begin
				want = pending_sums.pop_front();
				if (m_tdata[63:0] !== want.signature) begin
					$error("signature: expected %h, got %h", want.signature, m_tdata[63:0]);
					fail_count++;
				end
				if (m_tdata[68:64] !== want.kept_entries) begin
					$error("kept_entries: expected %0d, got %0d", want.kept_entries,
						m_tdata[68:64]);
					fail_count++;
				end
			end
		end
	end

	initial begin
		int          cut_mid;
		int          phase_items;
		int          drain_wait;
		int unsigned keep_pick;
		logic        last;
		script_row_t r;
		set_sum_t    none;

		// Every input known from time zero, with reset asserted at the start.
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = '0;
		cfg_data    = '0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tlast     = 1'b0;
		m_tready    = 1'b0;
		stall_style = 0;
		style_left  = 0;
		fail_count  = 0;
		burst_left  = 0;
		set_left    = 0;
		kept_now    = 0;
		seen_in_set = 0;
		keep_reg    = 5'd4;
		mode_reg    = MODE_KEEP_SMALL;
		none        = '0;
		for (int i = 0; i < KEEP_LIMIT; i++) begin
			kept_store[i] = '0;
		end

		// Scripted rows, starting from the reset setting: keep four, keep smallest.
		// A set of one zero label, and a set of one all-ones label.
		script_rows.push_back(summed_row(64'd0, 64'd0, 1));
		script_rows.push_back(summed_row({64{1'b1}}, {64{1'b1}}, 1));
		// Repeated labels during seeding collapse into one entry.
		script_rows.push_back(item_row(64'd5, 1'b0));
		script_rows.push_back(item_row(64'd5, 1'b0));
		script_rows.push_back(item_row(64'd5, 1'b0));
		script_rows.push_back(summed_row(64'd7, 64'd12, 2));
		// The sum wraps past the top of the 64-bit range.
		script_rows.push_back(item_row({64{1'b1}}, 1'b0));
		script_rows.push_back(summed_row(64'd2, 64'd1, 2));
		// A full seed followed by a replacement, a repeat of the new entry, a label
		// that is no better, and a last label already kept.
		script_rows.push_back(item_row(64'd40, 1'b0));
		script_rows.push_back(item_row(64'd10, 1'b0));
		script_rows.push_back(item_row(64'd30, 1'b0));
		script_rows.push_back(item_row(64'd20, 1'b0));
		script_rows.push_back(item_row(64'd5, 1'b0));
		script_rows.push_back(item_row(64'd5, 1'b0));
		script_rows.push_back(item_row(64'd100, 1'b0));
		script_rows.push_back(item_row(64'd30, 1'b1));
		// A keep count of zero behaves as one; keep the largest label.
		script_rows.push_back(write_row(REG_KEEP_COUNT, 5'd0));
		script_rows.push_back(write_row(REG_SELECT_MODE, {4'b1010, MODE_KEEP_LARGE}));
		script_rows.push_back(item_row(64'd3, 1'b0));
		script_rows.push_back(item_row(64'd9, 1'b0));
		script_rows.push_back(item_row(64'd2, 1'b0));
		script_rows.push_back(summed_row(64'd9, 64'd9, 1));
		// The largest keep count, then the count is lowered part way through a set, so
		// the next label is already past seeding.
		script_rows.push_back(write_row(REG_KEEP_COUNT, 5'd31));
		script_rows.push_back(write_row(REG_SELECT_MODE, {4'b0101, MODE_KEEP_SMALL}));
		script_rows.push_back(item_row(64'd7, 1'b0));
		script_rows.push_back(item_row(64'd3, 1'b0));
		script_rows.push_back(write_row(REG_KEEP_COUNT, 5'd1));
		script_rows.push_back(item_row(64'd1, 1'b1));

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (script_rows[i]) begin
			r = script_rows[i];
			if (r.is_write) begin
				settle();
				write_reg(r.reg_index, r.reg_value);
			end else begin
				offer_item(r.label, r.last, r.typed, r.typed_sum);
			end
		end

		// Random phases. The first ones take the keep count extremes and the values
		// around the store size; later ones pick any count. Some phases stop in the
		// middle of a set, which the next phase finishes under its new setting.
		for (int p = 0; p < PHASE_COUNT; p++) begin
			settle();
			case (p)
				0:       keep_pick = 16;
				1:       keep_pick = 17;
				2:       keep_pick = 0;
				3:       keep_pick = 1;
				4:       keep_pick = 31;
				default: keep_pick = $urandom_range(0, 31);
			endcase
			write_reg(REG_KEEP_COUNT, keep_pick[CFG_DATA_W-1:0]);
			write_reg(REG_SELECT_MODE, {4'($urandom_range(0, 15)),
				(p < 4) ? logic'(p % 2) : logic'($urandom_range(0, 1))});
			cut_mid     = ($urandom_range(0, 2) == 0);
			phase_items = 0;
			forever begin
				if (set_left <= 0) begin
					// Mostly sets around the seed length, some very short, some long.
					case ($urandom_range(0, 4))
						0:       set_left = $urandom_range(1, 3);
						4:       set_left = $urandom_range(1, 60);
						default: set_left = $urandom_range(1, 2 * effective_keep() + 4);
					endcase
				end
				last = (set_left == 1);
				offer_item(pick_label(), last, 1'b0, none);
				set_left--;
				phase_items++;
				if (phase_items >= PHASE_ITEMS && (cut_mid || last)) begin
					break;
				end
			end
		end

		// Finish the last set so that its result is checked too.
		while (set_left > 0) begin
			offer_item(pick_label(), set_left == 1, 1'b0, none);
			set_left--;
		end

		s_tvalid   = 1'b0;
		drain_wait = 0;
		while (pending_sums.size() != 0 && drain_wait < DRAIN_LIMIT) begin
			@(negedge clk);
			drain_wait++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);

		if (pending_sums.size() != 0) begin
			$error("%0d predicted result items never arrived", pending_sums.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("testbench: clean");
		end else begin
			$display("testbench: errors");
		end
		$finish;
	end

endmodule
